// ===== design/rmwab_pkg.sv =====
// Shared types, constants and command codes for the masked word access bridge.
`default_nettype none

package rmwab_pkg;

    localparam int STORE_ADDR_BITS = 10;
    localparam int STORE_DEPTH     = 1 << STORE_ADDR_BITS;
    localparam int WORD_BITS       = 32;
    localparam int HALF_BITS       = 16;

    localparam logic [7:0] CMD_ADDR       = 8'h00;
    localparam logic [7:0] CMD_DATA_LOW   = 8'h01;
    localparam logic [7:0] CMD_DATA_HIGH  = 8'h02;
    localparam logic [7:0] CMD_MASK_LOW   = 8'h03;
    localparam logic [7:0] CMD_MASK_HIGH  = 8'h04;
    localparam logic [7:0] CMD_READ_LOW   = 8'h05;
    localparam logic [7:0] CMD_READ_HIGH  = 8'h06;
    localparam logic [7:0] CMD_LANE_FLAGS = 8'h10;

    localparam logic [WORD_BITS-1:0] LOW_HALF_SEL  = 32'h0000_ffff;
    localparam logic [WORD_BITS-1:0] HIGH_HALF_SEL = 32'hffff_0000;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] data_low;
        logic [7:0] data_high;
    } t_in_item;

    typedef struct packed {
        logic [7:0] status_low;
        logic [7:0] status_high;
        logic [7:0] lane_flags;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/remote_masked_word_access_bridge_core.sv =====
// Top level of the masked word access bridge: command decode, word store and result register.
`default_nettype none

// Usage
// The input channel carries one command transfer (command, data_low, data_high) per item;
// the output channel returns exactly one result transfer (status_low, status_high,
// lane_flags) per command, in order. Both channels use valid and stall.
// Each command is handled in an accept cycle and an execute state: the accept cycle launches
// a read of the addressed word from the single-port synchronous word store, and in the
// execute state that follows, once the output register is free, the block merges the masked
// half-word for a data command, writes it back and loads the result register. Input stall
// stays high until then, so no new command is accepted before the last one has executed.
// After reset every control register clears and the block sweeps the word store, writing
// zero to one word per cycle across all 2**STORE_ADDR_BITS words (1024 with the default
// setting); input stall stays high during that sweep.
// A stalled result holds in the output register. The next command can still be accepted
// while a result waits; that command then parks in its execute cycle, with its read data
// held, until the output register frees up, and input stall stays high meanwhile.
// Only the low STORE_ADDR_BITS bits of the 16-bit target address select a word.
module remote_masked_word_access_bridge_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  rmwab_pkg::t_in_item i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output rmwab_pkg::t_out_item o_out_item,
    input  wire                 i_out_stall
);

    // Control and architectural registers.
    rmwab_pkg::t_state r_state, n_state;
    logic [rmwab_pkg::STORE_ADDR_BITS-1:0] r_clr_idx, n_clr_idx;
    logic [15:0]                   r_addr, n_addr;
    logic [rmwab_pkg::WORD_BITS-1:0] r_mask, n_mask;
    logic [rmwab_pkg::WORD_BITS-1:0] r_wval, n_wval;
    logic [15:0]                   r_status, n_status;
    logic [7:0]                    r_lanes, n_lanes;
    logic                          r_out_valid, n_out_valid;

    // Captured command of the item in flight.
    rmwab_pkg::t_in_item r_cmd_item;

    // Word store with one write port and one registered read port.
    logic [rmwab_pkg::WORD_BITS-1:0] r_mem [rmwab_pkg::STORE_DEPTH];
    logic [rmwab_pkg::WORD_BITS-1:0] r_rd_data;
    logic                            mem_we;
    logic [rmwab_pkg::STORE_ADDR_BITS-1:0] mem_waddr;
    logic [rmwab_pkg::WORD_BITS-1:0] mem_wdata;
    logic                            mem_re;

    logic                            in_accept;
    logic                            out_free;
    logic [rmwab_pkg::HALF_BITS-1:0] half;
    logic [rmwab_pkg::WORD_BITS-1:0] half_sel;
    logic [rmwab_pkg::WORD_BITS-1:0] bit_sel;
    logic [rmwab_pkg::STORE_ADDR_BITS-1:0] slot;

    assign slot       = r_addr[rmwab_pkg::STORE_ADDR_BITS-1:0];
    assign o_in_stall = (r_state != rmwab_pkg::ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign mem_re     = in_accept;
    assign half       = {r_cmd_item.data_high, r_cmd_item.data_low};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmwab_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_addr      <= '0;
            r_mask      <= '0;
            r_wval      <= '0;
            r_status    <= '0;
            r_lanes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_addr      <= n_addr;
            r_mask      <= n_mask;
            r_wval      <= n_wval;
            r_status    <= n_status;
            r_lanes     <= n_lanes;
            r_out_valid <= n_out_valid;
        end
    end

    // Next-state logic: store sweep, accept, and the read-modify-write step.
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_addr      = r_addr;
        n_mask      = r_mask;
        n_wval      = r_wval;
        n_status    = r_status;
        n_lanes     = r_lanes;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = slot;
        mem_wdata   = r_rd_data;
        half_sel    = '0;
        bit_sel     = '0;

        // The output register empties when its transfer completes.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rmwab_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                n_clr_idx = r_clr_idx + {{(rmwab_pkg::STORE_ADDR_BITS-1){1'b0}}, 1'b1};
                if (r_clr_idx == '1) begin
                    n_state = rmwab_pkg::ST_IDLE;
                end
            end
            rmwab_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = rmwab_pkg::ST_EXEC;
                end
            end
            rmwab_pkg::ST_EXEC: begin
                if (out_free) begin
                    case (r_cmd_item.command)
                        rmwab_pkg::CMD_ADDR: begin
                            n_addr = half;
                        end
                        rmwab_pkg::CMD_DATA_LOW: begin
                            n_wval   = {r_wval[31:16], half};
                            half_sel = rmwab_pkg::LOW_HALF_SEL;
                            mem_we   = 1'b1;
                        end
                        rmwab_pkg::CMD_DATA_HIGH: begin
                            n_wval   = {half, r_wval[15:0]};
                            half_sel = rmwab_pkg::HIGH_HALF_SEL;
                            mem_we   = 1'b1;
                        end
                        rmwab_pkg::CMD_MASK_LOW: begin
                            n_mask = {r_mask[31:16], half};
                        end
                        rmwab_pkg::CMD_MASK_HIGH: begin
                            n_mask = {half, r_mask[15:0]};
                        end
                        rmwab_pkg::CMD_READ_LOW: begin
                            n_status = r_rd_data[15:0];
                        end
                        rmwab_pkg::CMD_READ_HIGH: begin
                            n_status = r_rd_data[31:16];
                        end
                        rmwab_pkg::CMD_LANE_FLAGS: begin
                            n_lanes = (r_lanes & ~r_cmd_item.data_high)
                                    | (r_cmd_item.data_low & r_cmd_item.data_high);
                        end
                        default: begin
                        end
                    endcase
                    bit_sel     = half_sel & r_mask;
                    mem_wdata   = (r_rd_data & ~bit_sel) | (n_wval & bit_sel);
                    n_out_valid = 1'b1;
                    n_state     = rmwab_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmwab_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid            = r_out_valid;
    assign o_out_item.status_low  = r_status[7:0];
    assign o_out_item.status_high = r_status[15:8];
    assign o_out_item.lane_flags  = r_lanes;

endmodule

`default_nettype wire

// ===== design/rmwab_checker.sv =====
// Port-level checker for the masked word access bridge, with its bind statement.
`default_nettype none

module rmwab_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input rmwab_pkg::t_in_item  i_in_item,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input rmwab_pkg::t_out_item o_out_item,
    input wire                  i_out_stall
);

    // A reset starts the store sweep, so input is held off right after it.
    a_reset_stalls_input: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A command occupies the block for its execute cycle.
    a_one_command_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second command taken during execute");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind remote_masked_word_access_bridge_core rmwab_checker u_rmwab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ===== bench/remote_masked_word_access_bridge_core_tb.sv =====
// Self-checking testbench for the masked word access bridge core.
`default_nettype none

module remote_masked_word_access_bridge_core_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int DIR_COUNT      = 25;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int IDLE_PERCENT   = 28;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 8;
    // The clearing sweep writes all STORE_DEPTH words and each command waits out whatever
    // gaps the two sides insert; this limit leaves a wide margin.
    localparam int CYCLE_LIMIT    = 200000;

    // Codes that the decoder does not know; they must leave all state alone.
    localparam logic [7:0] CMD_UNUSED_LOW  = 8'h07;
    localparam logic [7:0] CMD_UNUSED_NEAR = 8'h11;
    localparam logic [7:0] CMD_UNUSED_TOP  = 8'hff;

    // One directed row: the command transfer, and optionally a result typed in by hand.
    typedef struct packed {
        rmwab_pkg::t_in_item  item;
        logic                 typed;
        rmwab_pkg::t_out_item want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    rmwab_pkg::t_in_item  in_item = '0;
    logic                 out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    rmwab_pkg::t_out_item o_out_item;

    // Mirror of the bridge state, advanced once per accepted command transfer.
    logic [15:0]                     addr_model;
    logic [rmwab_pkg::WORD_BITS-1:0] mask_model;
    logic [rmwab_pkg::WORD_BITS-1:0] wdata_model;
    logic [rmwab_pkg::WORD_BITS-1:0] store_model [rmwab_pkg::STORE_DEPTH];
    logic [15:0]                     status_model;
    logic [7:0]                      flags_model;

    rmwab_pkg::t_out_item result_q [$];

    int  cycle_count   = 0;
    int  error_count   = 0;
    int  results_seen  = 0;
    int  commands_sent = 0;
    int  reads_sent    = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    logic quiet        = 1'b0;

    // Directed rows. The first ones can be read straight off the command set:
    // reads after reset, full-scale flag updates, all-ones writes and the address
    // wrap. Everything after that is left to the predictor.
    t_dir_row dir_rows [DIR_COUNT] = '{
        '{'{rmwab_pkg::CMD_READ_LOW,   8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00}},
        '{'{rmwab_pkg::CMD_LANE_FLAGS, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'hff}},
        '{'{rmwab_pkg::CMD_LANE_FLAGS, 8'h00, 8'h0f}, 1'b1, '{8'h00, 8'h00, 8'hf0}},
        '{'{rmwab_pkg::CMD_LANE_FLAGS, 8'ha5, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'hf0}},
        '{'{rmwab_pkg::CMD_MASK_LOW,   8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'hf0}},
        '{'{rmwab_pkg::CMD_MASK_HIGH,  8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'hf0}},
        '{'{rmwab_pkg::CMD_ADDR,       8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'hf0}},
        '{'{rmwab_pkg::CMD_DATA_LOW,   8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'hf0}},
        '{'{rmwab_pkg::CMD_DATA_HIGH,  8'h00, 8'h80}, 1'b1, '{8'h00, 8'h00, 8'hf0}},
        '{'{rmwab_pkg::CMD_READ_LOW,   8'h00, 8'h00}, 1'b1, '{8'hff, 8'hff, 8'hf0}},
        '{'{rmwab_pkg::CMD_READ_HIGH,  8'h00, 8'h00}, 1'b1, '{8'h00, 8'h80, 8'hf0}},
        '{'{rmwab_pkg::CMD_ADDR,       8'hff, 8'h07}, 1'b1, '{8'h00, 8'h80, 8'hf0}},
        '{'{rmwab_pkg::CMD_READ_LOW,   8'h00, 8'h00}, 1'b1, '{8'hff, 8'hff, 8'hf0}},
        '{'{rmwab_pkg::CMD_MASK_LOW,   8'hf0, 8'h00}, 1'b0, '0},
        '{'{rmwab_pkg::CMD_DATA_LOW,   8'h34, 8'h12}, 1'b0, '0},
        '{'{rmwab_pkg::CMD_READ_LOW,   8'h00, 8'h00}, 1'b0, '0},
        '{'{CMD_UNUSED_TOP,            8'h55, 8'haa}, 1'b0, '0},
        '{'{CMD_UNUSED_LOW,            8'h00, 8'h00}, 1'b0, '0},
        '{'{CMD_UNUSED_NEAR,           8'hff, 8'hff}, 1'b0, '0},
        '{'{rmwab_pkg::CMD_MASK_HIGH,  8'h00, 8'h00}, 1'b0, '0},
        '{'{rmwab_pkg::CMD_DATA_HIGH,  8'hff, 8'hff}, 1'b0, '0},
        '{'{rmwab_pkg::CMD_READ_HIGH,  8'h00, 8'h00}, 1'b0, '0},
        '{'{rmwab_pkg::CMD_ADDR,       8'h00, 8'h00}, 1'b0, '0},
        '{'{rmwab_pkg::CMD_READ_HIGH,  8'h00, 8'h00}, 1'b0, '0},
        '{'{rmwab_pkg::CMD_LANE_FLAGS, 8'h00, 8'hff}, 1'b0, '0}
    };

    remote_masked_word_access_bridge_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_item  (in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(out_stall)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Safety net: a hung handshake ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d results still expected",
                 $time, cycle_count, result_q.size());
        $display("remote_masked_word_access_bridge_core_tb: done, errors");
        $finish;
    end

    // Apply one command to the mirrored state and return the status it leaves behind.
    // The word index is taken before the case so that an address command never
    // affects the word touched by its own transfer.
    function automatic rmwab_pkg::t_out_item bridge_apply(input rmwab_pkg::t_in_item it);
        logic [15:0]                           half;
        logic [rmwab_pkg::STORE_ADDR_BITS-1:0] idx;
        logic [rmwab_pkg::WORD_BITS-1:0]       sel;
        rmwab_pkg::t_out_item                  res;
        half = {it.data_high, it.data_low};
        idx  = addr_model[rmwab_pkg::STORE_ADDR_BITS-1:0];
        sel  = '0;
        case (it.command)
            rmwab_pkg::CMD_ADDR: addr_model = half;
            rmwab_pkg::CMD_DATA_LOW: begin
                wdata_model[15:0] = half;
                sel = rmwab_pkg::LOW_HALF_SEL & mask_model;
            end
            rmwab_pkg::CMD_DATA_HIGH: begin
                wdata_model[31:16] = half;
                sel = rmwab_pkg::HIGH_HALF_SEL & mask_model;
            end
            rmwab_pkg::CMD_MASK_LOW:   mask_model[15:0]  = half;
            rmwab_pkg::CMD_MASK_HIGH:  mask_model[31:16] = half;
            rmwab_pkg::CMD_READ_LOW:   status_model = store_model[idx][15:0];
            rmwab_pkg::CMD_READ_HIGH:  status_model = store_model[idx][31:16];
            rmwab_pkg::CMD_LANE_FLAGS: flags_model = (flags_model & ~it.data_high)
                                                     | (it.data_low & it.data_high);
            default: ;
        endcase
        // A zero select leaves the word untouched, so the merge can run for every command.
        store_model[idx] = (store_model[idx] & ~sel) | (wdata_model & sel);
        res.status_low  = status_model[7:0];
        res.status_high = status_model[15:8];
        res.lane_flags  = flags_model;
        return res;
    endfunction

    // Offer one command transfer. Entered and left just after a falling edge. The
    // payload stays put while the input is stalled, and the expectation is queued at
    // the edge where the transfer is taken.
    task automatic send_command(input rmwab_pkg::t_in_item it, input logic typed,
                                input rmwab_pkg::t_out_item want);
        rmwab_pkg::t_out_item predicted;
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_item  = it;
        in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predicted = bridge_apply(it);
        result_q.push_back(typed ? want : predicted);
        commands_sent++;
        if (it.command == rmwab_pkg::CMD_READ_LOW || it.command == rmwab_pkg::CMD_READ_HIGH)
            reads_sent++;
        @(negedge i_clk);
    endtask

    // Result side stall: random idling, nothing during the quiet stretch, and a long
    // hold-off whenever the stimulus asks for one, counted down here cycle by cycle.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall = 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD - 1;
            out_stall   = 1'b1;
        end else begin
            out_stall = !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Every result transfer is checked field by field against the oldest expectation.
    always @(posedge i_clk) begin
        rmwab_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_out_item);
            end else begin
                want = result_q.pop_front();
                results_seen++;
                if (o_out_item.status_low !== want.status_low) begin
                    error_count++;
                    $display("%0t: status_low mismatch, expected %h, actual %h",
                             $time, want.status_low, o_out_item.status_low);
                end
                if (o_out_item.status_high !== want.status_high) begin
                    error_count++;
                    $display("%0t: status_high mismatch, expected %h, actual %h",
                             $time, want.status_high, o_out_item.status_high);
                end
                if (o_out_item.lane_flags !== want.lane_flags) begin
                    error_count++;
                    $display("%0t: lane_flags mismatch, expected %h, actual %h",
                             $time, want.lane_flags, o_out_item.lane_flags);
                end
            end
        end
    end

    initial begin
        rmwab_pkg::t_in_item it;
        int                  pick;
        addr_model   = '0;
        mask_model   = '0;
        wdata_model  = '0;
        status_model = '0;
        flags_model  = '0;
        foreach (store_model[k]) store_model[k] = '0;

        // Synchronous reset, then the block clears its store on its own with the
        // input stalled; the first transfer simply waits for that to finish.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) send_command(dir_rows[r].item, dir_rows[r].typed,
                                           dir_rows[r].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Two long output hold-offs fill the block while commands keep coming,
            // and one stretch runs with no idling on either side.
            if (n == 300 || n == 1200) hold_requests++;
            quiet = (n >= 700 && n < 1000);

            pick = $urandom_range(0, 99);
            it.data_low  = 8'($urandom);
            it.data_high = 8'($urandom);
            if (pick < 14) begin
                it.command = rmwab_pkg::CMD_ADDR;
                // Mostly a handful of words, reached through aliases above the index
                // bits, so that writes and reads meet; sometimes any address at all.
                if ($urandom_range(0, 3) != 0)
                    {it.data_high, it.data_low} =
                        16'($urandom_range(0, 63) << rmwab_pkg::STORE_ADDR_BITS)
                        | 16'($urandom_range(0, 7));
            end else if (pick < 26) begin
                it.command = rmwab_pkg::CMD_DATA_LOW;
            end else if (pick < 38) begin
                it.command = rmwab_pkg::CMD_DATA_HIGH;
            end else if (pick < 46) begin
                it.command = rmwab_pkg::CMD_MASK_LOW;
            end else if (pick < 54) begin
                it.command = rmwab_pkg::CMD_MASK_HIGH;
            end else if (pick < 68) begin
                it.command = rmwab_pkg::CMD_READ_LOW;
            end else if (pick < 82) begin
                it.command = rmwab_pkg::CMD_READ_HIGH;
            end else if (pick < 90) begin
                it.command = rmwab_pkg::CMD_LANE_FLAGS;
            end else begin
                // Any byte at all, so every command bit toggles and unknown codes appear.
                it.command = 8'($urandom);
            end
            send_command(it, 1'b0, '0);
        end
        in_valid = 1'b0;
        quiet    = 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d command transfers (%0d directed, %0d reads), checked %0d results,",
                 commands_sent, DIR_COUNT, reads_sent, results_seen);
        $display("with random idling, a quiet stretch and %0d long output hold-offs.",
                 hold_served);
        if (error_count == 0) begin
            $display("remote_masked_word_access_bridge_core_tb: done, clean");
        end else begin
            $display("remote_masked_word_access_bridge_core_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
